[hdl/fesq_pkg.sv]
// fesq_pkg: shared types of the flash erase / program sequencer
// holds the phase encoding and the step result bundle
// no dependencies
`default_nettype none

package fesq_pkg;

    // sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_ERASE_BUSY = 3'd1,
        PH_ERASE_PROG = 3'd2,
        PH_WRITE_BUSY = 3'd3,
        PH_WRITE_PROG = 3'd4
    } phase_t;

    // step call kinds
    localparam logic REQ_ERASE = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // bytes per programmed word
    localparam logic [20:0] WORD_BYTES = 21'd4;

    // one step result
    typedef struct packed {
        logic        unlock_pulse;
        logic        lock_pulse;
        logic        erase_start;
        logic        program_word;
        logic        clear_erase;
        logic        clear_program;
        logic        bank_sel;
        logic [20:0] flash_offset;
        logic [31:0] write_word;
        logic        mirror_addr0;
        logic        done_res;
        logic        error;
    } result_t;

endpackage

`default_nettype wire

[hdl/fesq_step.sv]
// fesq_step: combinational step logic of the erase / program sequencer
// computes next phase, next address and remainder, and the step result
// depends on fesq_pkg
`default_nettype none

module fesq_step #(
    parameter int unsigned FLASH_KIB        = 1024,
    parameter int unsigned BANK0_KIB        = 512,
    parameter int unsigned BANK0_PAGE_BYTES = 2048,
    parameter int unsigned BANK1_PAGE_BYTES = 4096
) (
    input  fesq_pkg::phase_t  phase,
    input  logic [20:0]       cur_offset,
    input  logic [20:0]       remaining_bytes,
    input  logic              req_type,
    input  logic [19:0]       start_offset,
    input  logic [20:0]       start_length,
    input  logic [31:0]       data_word,
    input  logic              bank0_busy,
    input  logic              bank1_busy,
    input  logic              security_on,
    output fesq_pkg::phase_t  phase_next,
    output logic [20:0]       cur_offset_next,
    output logic [20:0]       remaining_next,
    output fesq_pkg::result_t res
);

    localparam logic [23:0] FLASH_BYTES = 24'(FLASH_KIB * 1024);
    localparam logic [23:0] BANK0_BYTES = 24'(BANK0_KIB * 1024);
    localparam logic        HAS_BANK1   = (BANK0_KIB < FLASH_KIB);
    localparam logic [16:0] PAGE0       = 17'(BANK0_PAGE_BYTES);
    localparam logic [16:0] PAGE1       = 17'(BANK1_PAGE_BYTES);

    function automatic logic bank_of(input logic [20:0] off);
        return HAS_BANK1 && ({3'b000, off} >= BANK0_BYTES);
    endfunction

    logic        cur_bank;
    logic        start_bank;
    logic        busy;
    logic        rem_zero;
    logic [16:0] page;
    logic [20:0] rem_after_page;
    logic [20:0] rem_after_word;
    logic [23:0] write_end;
    logic        write_ok;

    // bank selection, busy poll and write request check
    always_comb
    begin
        cur_bank   = bank_of(cur_offset);
        start_bank = bank_of({1'b0, start_offset});
        busy       = cur_bank ? bank1_busy : bank0_busy;
        rem_zero   = (remaining_bytes == 21'd0);
        page       = cur_bank ? PAGE1 : PAGE0;
        rem_after_page = (remaining_bytes >= {4'b0000, page})
                       ? remaining_bytes - {4'b0000, page} : 21'd0;
        rem_after_word = (remaining_bytes >= fesq_pkg::WORD_BYTES)
                       ? remaining_bytes - fesq_pkg::WORD_BYTES : 21'd0;
        write_end  = {4'b0000, start_offset} + {3'b000, start_length};
        write_ok   = (start_length != 21'd0) && (start_length[1:0] == 2'b00)
                  && ({4'b0000, start_offset} < FLASH_BYTES)
                  && (write_end <= FLASH_BYTES);
    end

    // next phase
    always_comb
    begin
        phase_next = phase;
        unique case (phase)
            fesq_pkg::PH_IDLE:
            begin
                if (req_type == fesq_pkg::REQ_ERASE)
                    phase_next = fesq_pkg::PH_ERASE_BUSY;
                else
                    phase_next = write_ok ? fesq_pkg::PH_WRITE_PROG : fesq_pkg::PH_IDLE;
            end
            fesq_pkg::PH_ERASE_BUSY:
            begin
                if (req_type == fesq_pkg::REQ_WRITE)
                    phase_next = fesq_pkg::PH_IDLE;
                else if (!busy)
                    phase_next = rem_zero ? fesq_pkg::PH_IDLE : fesq_pkg::PH_ERASE_PROG;
            end
            fesq_pkg::PH_ERASE_PROG:
            begin
                phase_next = (req_type == fesq_pkg::REQ_ERASE)
                           ? fesq_pkg::PH_ERASE_BUSY : fesq_pkg::PH_IDLE;
            end
            fesq_pkg::PH_WRITE_BUSY:
            begin
                if (req_type == fesq_pkg::REQ_ERASE)
                    phase_next = fesq_pkg::PH_IDLE;
                else if (!busy)
                    phase_next = rem_zero ? fesq_pkg::PH_IDLE : fesq_pkg::PH_WRITE_PROG;
            end
            fesq_pkg::PH_WRITE_PROG:
            begin
                phase_next = (req_type == fesq_pkg::REQ_WRITE)
                           ? fesq_pkg::PH_WRITE_BUSY : fesq_pkg::PH_IDLE;
            end
            default:
                phase_next = fesq_pkg::PH_IDLE;
        endcase
    end

    // commands, address and remainder update
    always_comb
    begin
        res                 = '0;
        res.bank_sel        = cur_bank;
        res.flash_offset    = cur_offset;
        cur_offset_next     = cur_offset;
        remaining_next      = remaining_bytes;
        unique case (phase)
            fesq_pkg::PH_IDLE:
            begin
                if (req_type == fesq_pkg::REQ_WRITE && !write_ok)
                begin
                    res.error    = 1'b1;
                    res.done_res = 1'b1;
                end
                else
                begin
                    cur_offset_next  = {1'b0, start_offset};
                    remaining_next   = start_length;
                    res.flash_offset = {1'b0, start_offset};
                    res.bank_sel     = start_bank;
                    res.unlock_pulse = 1'b1;
                end
            end
            fesq_pkg::PH_ERASE_BUSY:
            begin
                if (req_type == fesq_pkg::REQ_WRITE)
                    res.clear_erase = 1'b1;
                else if (!busy)
                begin
                    res.clear_erase = 1'b1;
                    res.lock_pulse  = rem_zero;
                    res.done_res    = rem_zero;
                end
            end
            fesq_pkg::PH_ERASE_PROG:
            begin
                if (req_type == fesq_pkg::REQ_ERASE && !rem_zero)
                begin
                    res.erase_start  = 1'b1;
                    res.mirror_addr0 = cur_bank && security_on;
                    remaining_next   = rem_after_page;
                    cur_offset_next  = cur_offset + {4'b0000, page};
                end
            end
            fesq_pkg::PH_WRITE_BUSY:
            begin
                if (req_type == fesq_pkg::REQ_ERASE)
                    res.clear_program = 1'b1;
                else if (!busy)
                begin
                    res.clear_program = 1'b1;
                    res.lock_pulse    = rem_zero;
                    res.done_res      = rem_zero;
                    if (!rem_zero)
                        cur_offset_next = cur_offset + fesq_pkg::WORD_BYTES;
                end
            end
            fesq_pkg::PH_WRITE_PROG:
            begin
                if (req_type == fesq_pkg::REQ_WRITE)
                begin
                    res.program_word = 1'b1;
                    res.write_word   = data_word;
                    remaining_next   = rem_after_word;
                end
            end
            default:
            begin
                res.bank_sel = cur_bank;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/flash_erase_program_sequencer_unit.sv]
// flash_erase_program_sequencer_unit: top level of the two-bank flash sequencer
// holds the sequencer state and the result register, step logic in fesq_step
// depends on fesq_pkg and fesq_step
`default_nettype none

// Each input transfer is one step call (erase or write) and yields exactly one
// result transfer. The step is computed in a single pass of combinational logic
// from the phase, address and remainder registers and lands in the result
// register in the cycle after the input transfer. A new step is taken every cycle
// as long as the result register is empty or being drained in that cycle, so
// the sustained rate is one step per clock; the only stall source is out_ready.

module flash_erase_program_sequencer_unit #(
    parameter int unsigned FLASH_KIB        = 1024,
    parameter int unsigned BANK0_KIB        = 512,
    parameter int unsigned BANK0_PAGE_BYTES = 2048,
    parameter int unsigned BANK1_PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [19:0] start_offset,
    input  wire logic [20:0] start_length,
    input  wire logic [31:0] data_word,
    input  wire logic        bank0_busy,
    input  wire logic        bank1_busy,
    input  wire logic        security_on,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             unlock_pulse,
    output logic             lock_pulse,
    output logic             erase_start,
    output logic             program_word,
    output logic             clear_erase,
    output logic             clear_program,
    output logic             bank_sel,
    output logic [20:0]      flash_offset,
    output logic [31:0]      write_word,
    output logic             mirror_addr0,
    output logic             done_res,
    output logic             error
);

    fesq_pkg::phase_t  phase_reg;
    fesq_pkg::phase_t  phase_next;
    logic [20:0]       cur_offset_reg;
    logic [20:0]       cur_offset_next;
    logic [20:0]       remaining_reg;
    logic [20:0]       remaining_next;
    fesq_pkg::result_t res_next;
    fesq_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              in_fire;

    // accept while the result register is free or emptying
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    fesq_step #(
        .FLASH_KIB        (FLASH_KIB),
        .BANK0_KIB        (BANK0_KIB),
        .BANK0_PAGE_BYTES (BANK0_PAGE_BYTES),
        .BANK1_PAGE_BYTES (BANK1_PAGE_BYTES)
    ) u_step (
        .phase           (phase_reg),
        .cur_offset      (cur_offset_reg),
        .remaining_bytes (remaining_reg),
        .req_type        (req_type),
        .start_offset    (start_offset),
        .start_length    (start_length),
        .data_word       (data_word),
        .bank0_busy      (bank0_busy),
        .bank1_busy      (bank1_busy),
        .security_on     (security_on),
        .phase_next      (phase_next),
        .cur_offset_next (cur_offset_next),
        .remaining_next  (remaining_next),
        .res             (res_next)
    );

    // sequencer state, advanced once per input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fesq_pkg::PH_IDLE;
            cur_offset_reg <= 21'd0;
            remaining_reg  <= 21'd0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            cur_offset_reg <= cur_offset_next;
            remaining_reg  <= remaining_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    // output ports
    assign out_valid     = out_valid_reg;
    assign unlock_pulse  = res_reg.unlock_pulse;
    assign lock_pulse    = res_reg.lock_pulse;
    assign erase_start   = res_reg.erase_start;
    assign program_word  = res_reg.program_word;
    assign clear_erase   = res_reg.clear_erase;
    assign clear_program = res_reg.clear_program;
    assign bank_sel      = res_reg.bank_sel;
    assign flash_offset  = res_reg.flash_offset;
    assign write_word    = res_reg.write_word;
    assign mirror_addr0  = res_reg.mirror_addr0;
    assign done_res      = res_reg.done_res;
    assign error         = res_reg.error;

endmodule

`default_nettype wire

[hdl/fesq_checker.sv]
// fesq_checker: port-level checks of the flash erase / program sequencer
// attached to flash_erase_program_sequencer_unit by the bind below
// no package dependencies
`default_nettype none

module fesq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        unlock_pulse,
    input wire logic        lock_pulse,
    input wire logic        erase_start,
    input wire logic        program_word,
    input wire logic        clear_erase,
    input wire logic        clear_program,
    input wire logic        bank_sel,
    input wire logic [20:0] flash_offset,
    input wire logic [31:0] write_word,
    input wire logic        mirror_addr0,
    input wire logic        done_res,
    input wire logic        error
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({flash_offset, write_word, done_res, error, bank_sel}))
        else $error("result changed while stalled");

    // a rejected write also ends the operation
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> done_res && !unlock_pulse)
        else $error("error without done");

    // at most one flash command per step
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({unlock_pulse, lock_pulse, erase_start, program_word}) <= 1)
        else $error("more than one command in a step");

    // address mirroring only with a bank 1 page erase
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mirror_addr0 |-> erase_start && bank_sel)
        else $error("mirror without bank 1 erase");

    // word value only shown with a program command
    a_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !program_word |-> write_word == 32'd0)
        else $error("write word set without program");

endmodule

bind flash_erase_program_sequencer_unit fesq_checker u_fesq_checker (.*);

`default_nettype wire

[tb/fesq_step_checker.sv]
// fesq_step_checker: scoreboard for the two-bank flash erase / program sequencer
// predicts one step result per accepted input transfer and compares result transfers
// depends on fesq_pkg

module fesq_step_checker #(
    parameter int unsigned FLASH_KIB        = 1024,
    parameter int unsigned BANK0_KIB        = 512,
    parameter int unsigned BANK0_PAGE_BYTES = 2048,
    parameter int unsigned BANK1_PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        req_type,
    input  logic [19:0] start_offset,
    input  logic [20:0] start_length,
    input  logic [31:0] data_word,
    input  logic        bank0_busy,
    input  logic        bank1_busy,
    input  logic        security_on,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        unlock_pulse,
    input  logic        lock_pulse,
    input  logic        erase_start,
    input  logic        program_word,
    input  logic        clear_erase,
    input  logic        clear_program,
    input  logic        bank_sel,
    input  logic [20:0] flash_offset,
    input  logic [31:0] write_word,
    input  logic        mirror_addr0,
    input  logic        done_res,
    input  logic        error,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          erase_cmds,
    output int          program_cmds,
    output int          ops_done,
    output int          writes_rejected
);

    localparam int unsigned FLASH_BYTES = FLASH_KIB * 1024;
    localparam int unsigned BANK0_BYTES = BANK0_KIB * 1024;

    // shadow of the sequencer state
    fesq_pkg::phase_t op_phase;
    logic [20:0]      cur_addr;
    logic [20:0]      bytes_left;

    // predicted results waiting for their transfer
    fesq_pkg::result_t step_results_due[$];

    function automatic logic bank_of(logic [20:0] addr);
        if (BANK0_KIB < FLASH_KIB)
            return (int'(addr) >= BANK0_BYTES);
        return 1'b0;
    endfunction

    function automatic logic write_request_ok(logic [19:0] off, logic [20:0] len);
        if (len == '0 || len[1:0] != 2'b00)
            return 1'b0;
        if (int'(off) >= FLASH_BYTES)
            return 1'b0;
        return int'(len) <= FLASH_BYTES - int'(off);
    endfunction

    // one step of the sequencer: returns the result and advances the shadow state
    function automatic fesq_pkg::result_t predict_step(logic req, logic [19:0] s_off,
                                                       logic [20:0] s_len, logic [31:0] data,
                                                       logic busy0, logic busy1, logic sec);
        fesq_pkg::result_t r;
        logic              bank_busy;
        int unsigned       page;
        r = '0;
        r.flash_offset = cur_addr;
        r.bank_sel = bank_of(cur_addr);
        bank_busy = r.bank_sel ? busy1 : busy0;
        if (req == fesq_pkg::REQ_ERASE) begin
            case (op_phase)
                fesq_pkg::PH_IDLE:
                begin
                    cur_addr = {1'b0, s_off};
                    bytes_left = s_len;
                    r.flash_offset = {1'b0, s_off};
                    r.bank_sel = bank_of({1'b0, s_off});
                    r.unlock_pulse = 1'b1;
                    op_phase = fesq_pkg::PH_ERASE_BUSY;
                end
                fesq_pkg::PH_ERASE_BUSY:
                begin
                    if (!bank_busy)
                    begin
                        r.clear_erase = 1'b1;
                        if (bytes_left == '0)
                        begin
                            r.lock_pulse = 1'b1;
                            r.done_res = 1'b1;
                            op_phase = fesq_pkg::PH_IDLE;
                        end
                        else
                        begin
                            op_phase = fesq_pkg::PH_ERASE_PROG;
                        end
                    end
                end
                fesq_pkg::PH_ERASE_PROG:
                begin
                    if (bytes_left != '0)
                    begin
                        page = r.bank_sel ? BANK1_PAGE_BYTES : BANK0_PAGE_BYTES;
                        r.erase_start = 1'b1;
                        r.mirror_addr0 = r.bank_sel & sec;
                        bytes_left = (int'(bytes_left) >= page) ? bytes_left - 21'(page) : '0;
                        cur_addr = cur_addr + 21'(page);
                    end
                    op_phase = fesq_pkg::PH_ERASE_BUSY;
                end
                fesq_pkg::PH_WRITE_BUSY:
                begin
                    // erase call aborts a write waiting on busy
                    r.clear_program = 1'b1;
                    op_phase = fesq_pkg::PH_IDLE;
                end
                default:
                    op_phase = fesq_pkg::PH_IDLE;
            endcase
        end
        else
        begin
            case (op_phase)
                fesq_pkg::PH_IDLE:
                begin
                    if (!write_request_ok(s_off, s_len))
                    begin
                        r.error = 1'b1;
                        r.done_res = 1'b1;
                    end
                    else
                    begin
                        cur_addr = {1'b0, s_off};
                        bytes_left = s_len;
                        r.flash_offset = {1'b0, s_off};
                        r.bank_sel = bank_of({1'b0, s_off});
                        r.unlock_pulse = 1'b1;
                        op_phase = fesq_pkg::PH_WRITE_PROG;
                    end
                end
                fesq_pkg::PH_WRITE_BUSY:
                begin
                    if (!bank_busy)
                    begin
                        r.clear_program = 1'b1;
                        if (bytes_left == '0)
                        begin
                            r.lock_pulse = 1'b1;
                            r.done_res = 1'b1;
                            op_phase = fesq_pkg::PH_IDLE;
                        end
                        else
                        begin
                            cur_addr = cur_addr + fesq_pkg::WORD_BYTES;
                            op_phase = fesq_pkg::PH_WRITE_PROG;
                        end
                    end
                end
                fesq_pkg::PH_WRITE_PROG:
                begin
                    r.program_word = 1'b1;
                    r.write_word = data;
                    bytes_left = (bytes_left >= fesq_pkg::WORD_BYTES)
                               ? bytes_left - fesq_pkg::WORD_BYTES : '0;
                    op_phase = fesq_pkg::PH_WRITE_BUSY;
                end
                fesq_pkg::PH_ERASE_BUSY:
                begin
                    // write call aborts an erase waiting on busy
                    r.clear_erase = 1'b1;
                    op_phase = fesq_pkg::PH_IDLE;
                end
                default:
                    op_phase = fesq_pkg::PH_IDLE;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            if (fail_count < 10)
                $display("mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_checked, fname, want, seen);
            fail_count++;
        end
    endtask

    // compare the result transfer first, then queue the prediction for the input transfer
    always @(posedge clk or negedge rst_n)
    begin
        fesq_pkg::result_t want;
        if (!rst_n)
        begin
            op_phase <= fesq_pkg::PH_IDLE;
            cur_addr <= '0;
            bytes_left <= '0;
            step_results_due.delete();
            fail_count <= 0;
            pending <= 0;
            results_checked <= 0;
            erase_cmds <= 0;
            program_cmds <= 0;
            ops_done <= 0;
            writes_rejected <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (step_results_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result transfer with no step outstanding, offset 0x%0h",
                                 flash_offset);
                    fail_count++;
                end
                else
                begin
                    want = step_results_due.pop_front();
                    check_field("unlock_pulse", 32'(want.unlock_pulse), 32'(unlock_pulse));
                    check_field("lock_pulse", 32'(want.lock_pulse), 32'(lock_pulse));
                    check_field("erase_start", 32'(want.erase_start), 32'(erase_start));
                    check_field("program_word", 32'(want.program_word), 32'(program_word));
                    check_field("clear_erase", 32'(want.clear_erase), 32'(clear_erase));
                    check_field("clear_program", 32'(want.clear_program),
                                32'(clear_program));
                    check_field("bank_sel", 32'(want.bank_sel), 32'(bank_sel));
                    check_field("flash_offset", 32'(want.flash_offset), 32'(flash_offset));
                    check_field("write_word", want.write_word, write_word);
                    check_field("mirror_addr0", 32'(want.mirror_addr0), 32'(mirror_addr0));
                    check_field("done_res", 32'(want.done_res), 32'(done_res));
                    check_field("error", 32'(want.error), 32'(error));
                    results_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_step(req_type, start_offset, start_length, data_word,
                                    bank0_busy, bank1_busy, security_on);
                step_results_due.push_back(want);
                erase_cmds += int'(want.erase_start);
                program_cmds += int'(want.program_word);
                ops_done += int'(want.done_res && !want.error);
                writes_rejected += int'(want.error);
            end
            pending = step_results_due.size();
        end
    end

endmodule

[tb/flash_erase_program_sequencer_unit_tb.sv]
// flash_erase_program_sequencer_unit_tb: stimulus and verdict for the flash sequencer
// drives directed and random step calls with random idling on both channels
// depends on fesq_pkg, fesq_step_checker and flash_erase_program_sequencer_unit

module flash_erase_program_sequencer_unit_tb;

    localparam logic REQ_ERASE = fesq_pkg::REQ_ERASE;
    localparam logic REQ_WRITE = fesq_pkg::REQ_WRITE;

    localparam int RANDOM_STEPS = 80;
    localparam int STALL_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [19:0] start_offset;
    logic [20:0] start_length;
    logic [31:0] data_word;
    logic        bank0_busy;
    logic        bank1_busy;
    logic        security_on;
    logic        out_valid;
    logic        out_ready;
    logic        unlock_pulse;
    logic        lock_pulse;
    logic        erase_start;
    logic        program_word;
    logic        clear_erase;
    logic        clear_program;
    logic        bank_sel;
    logic [20:0] flash_offset;
    logic [31:0] write_word;
    logic        mirror_addr0;
    logic        done_res;
    logic        error;

    int fail_count;
    int pending;
    int results_checked;
    int erase_cmds;
    int program_cmds;
    int ops_done;
    int writes_rejected;

    int steps_sent;
    int idle_cycles;
    bit calm;

    flash_erase_program_sequencer_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .start_offset(start_offset), .start_length(start_length),
        .data_word(data_word), .bank0_busy(bank0_busy), .bank1_busy(bank1_busy),
        .security_on(security_on),
        .out_valid(out_valid), .out_ready(out_ready),
        .unlock_pulse(unlock_pulse), .lock_pulse(lock_pulse), .erase_start(erase_start),
        .program_word(program_word), .clear_erase(clear_erase),
        .clear_program(clear_program), .bank_sel(bank_sel), .flash_offset(flash_offset),
        .write_word(write_word), .mirror_addr0(mirror_addr0), .done_res(done_res),
        .error(error)
    );

    fesq_step_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .start_offset(start_offset), .start_length(start_length),
        .data_word(data_word), .bank0_busy(bank0_busy), .bank1_busy(bank1_busy),
        .security_on(security_on),
        .out_valid(out_valid), .out_ready(out_ready),
        .unlock_pulse(unlock_pulse), .lock_pulse(lock_pulse), .erase_start(erase_start),
        .program_word(program_word), .clear_erase(clear_erase),
        .clear_program(clear_program), .bank_sel(bank_sel), .flash_offset(flash_offset),
        .write_word(write_word), .mirror_addr0(mirror_addr0), .done_res(done_res),
        .error(error),
        .fail_count(fail_count), .pending(pending), .results_checked(results_checked),
        .erase_cmds(erase_cmds), .program_cmds(program_cmds), .ops_done(ops_done),
        .writes_rejected(writes_rejected)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long, none at all in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic busy_draw();
        return $urandom_range(0, 3) == 0;
    endfunction

    // low flash, around the bank edge, near the top, or anywhere
    function automatic logic [19:0] pick_offset();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 255));
            1: return 20'(32'h7C000 + $urandom_range(0, 32'h7FFF));
            2: return 20'(32'hF8000 + $urandom_range(0, 32'h7FFF));
            default: return 20'($urandom_range(0, 32'hFFFFF));
        endcase
    endfunction

    // one step call transfer
    task automatic send_step(input logic req, input logic [19:0] off, input logic [20:0] len,
                             input logic [31:0] data, input logic b0, input logic b1,
                             input logic sec);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type <= req;
        start_offset <= off;
        start_length <= len;
        data_word <= data;
        bank0_busy <= b0;
        bank1_busy <= b1;
        security_on <= sec;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        steps_sent++;
    endtask

    // a run of calls of one kind with random data, busy flags and security
    task automatic run_op(input logic req, input logic [19:0] off, input logic [20:0] len,
                          input int calls);
        repeat (calls)
            send_step(req, off, len, $urandom, busy_draw(), busy_draw(),
                      1'($urandom_range(0, 1)));
    endtask

    // result side stalls
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int first_random;
        int len;
        int pages;
        int words;
        logic [19:0] off;
        logic req;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        out_ready <= 1'b0;
        req_type <= REQ_ERASE;
        start_offset <= '0;
        start_length <= '0;
        data_word <= '0;
        bank0_busy <= 1'b0;
        bank1_busy <= 1'b0;
        security_on <= 1'b0;
        steps_sent = 0;
        calm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rejected writes: empty, unaligned length, past the end, longer than flash
        send_step(REQ_WRITE, 20'h00000, 21'h000000, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'h00100, 21'h000006, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'hFFFF0, 21'h000014, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'h00000, 21'h100004, 32'h0, 1'b0, 1'b0, 1'b0);

        // one word ending exactly at the top of flash, busy poll in bank 1
        send_step(REQ_WRITE, 20'hFFFFC, 21'h000004, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'hFFFFC, 21'h000004, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'hFFFFC, 21'h000004, 32'h0, 1'b0, 1'b1, 1'b0);
        send_step(REQ_WRITE, 20'hFFFFC, 21'h000004, 32'h0, 1'b0, 1'b0, 1'b0);

        // erase crossing from bank 0 into bank 1 with security, short remainder clamps
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b0, 1'b0, 1'b1);
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b1, 1'b0, 1'b1);
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b0, 1'b0, 1'b1);
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b0, 1'b0, 1'b1);
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b1, 1'b0, 1'b1);
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b0, 1'b0, 1'b1);
        send_step(REQ_ERASE, 20'h7F800, 21'h001000, 32'h0, 1'b0, 1'b0, 1'b1);

        // zero-length erase finishes at the first poll
        send_step(REQ_ERASE, 20'h12345, 21'h000000, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_ERASE, 20'h12345, 21'h000000, 32'h0, 1'b0, 1'b0, 1'b0);

        // aborts from each busy and program phase
        send_step(REQ_WRITE, 20'h00100, 21'h000008, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'h00100, 21'h000008, 32'hA5A5A5A5, 1'b0, 1'b0, 1'b0);
        send_step(REQ_ERASE, 20'h00100, 21'h000008, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_ERASE, 20'h00200, 21'h000800, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'h00200, 21'h000800, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_ERASE, 20'h00200, 21'h000800, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_ERASE, 20'h00200, 21'h000800, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'h00000, 21'h100000, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_WRITE, 20'h00000, 21'h100000, 32'h0, 1'b0, 1'b0, 1'b0);
        send_step(REQ_ERASE, 20'h00000, 21'h100000, 32'h0, 1'b0, 1'b0, 1'b0);

        // random operations, mostly complete ones
        first_random = steps_sent;
        while (steps_sent - first_random < RANDOM_STEPS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            off = pick_offset();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12288);
                    pages = len / 2048 + 1;
                    run_op(REQ_ERASE, off, 21'(len), 2 + 3 * pages + $urandom_range(0, 2));
                end
                8, 9, 10, 11, 12, 13, 14:
                begin
                    words = $urandom_range(1, 10);
                    len = 4 * words;
                    if ($urandom_range(0, 9) == 0)
                        off = 20'((1 << 20) - len);
                    else if ($urandom_range(0, 6) == 0)
                        len = $urandom_range(0, 40);
                    run_op(REQ_WRITE, off, 21'(len), 2 + 3 * words + $urandom_range(0, 2));
                end
                15, 16:
                begin
                    // operation cut short by a call of the other kind
                    req = 1'($urandom_range(0, 1));
                    run_op(req, off, 21'(4 * $urandom_range(1, 1024)), $urandom_range(1, 6));
                    run_op(!req, pick_offset(), 21'($urandom_range(0, 4096)), 1);
                end
                default:
                begin
                    // noise over the full field widths
                    repeat ($urandom_range(1, 4))
                        send_step(1'($urandom_range(0, 1)), 20'($urandom),
                                  21'($urandom), $urandom, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            endcase
        end

        // erase from the last byte through the address wrap back into bank 0
        calm = 1'b0;
        repeat (516)
            send_step(REQ_ERASE, 20'hFFFFF, 21'h101000, $urandom, 1'b0, 1'b0,
                      1'($urandom_range(0, 1)));

        // let the last transfer reach the scoreboard before watching it drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d step calls, %0d results checked, %0d mismatches",
                 steps_sent, results_checked, fail_count);
        $display("%0d page erases, %0d word programs, %0d completed operations, %0d rejected writes",
                 erase_cmds, program_cmds, ops_done, writes_rejected);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
